/* rtl/core/tlvmv_pkg.sv */
package tlvmv_pkg;

   localparam int POSITION_BITS = 32;
   localparam int POS_CMP_BITS  = (POSITION_BITS > 32) ? POSITION_BITS : 32;
   localparam int HEADER_BYTES  = 8;
   localparam int TLV_HEAD_BYTES = 4;

   typedef enum logic [1:0] {
      PH_HEADER    = 2'd0,
      PH_TLV_HEAD  = 2'd1,
      PH_TLV_VALUE = 2'd2,
      PH_PAYLOAD   = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      ST_VALID        = 3'd0,
      ST_SHORT_HEADER = 3'd1,
      ST_TLV_HEAD_CUT = 3'd2,
      ST_TLV_VALUE_CUT = 3'd3,
      ST_PAYLOAD_CUT  = 3'd4,
      ST_NONE         = 3'd5
   } status_type;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       last_byte;
   } item_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] msg_type;
      logic [15:0] tlv_count;
      logic [31:0] payload_length;
      logic [31:0] payload_offset;
      logic        found;
      logic [31:0] found_offset;
      logic [15:0] found_length;
   } result_type;

   function automatic status_type phase_status(phase_type ph);
      status_type s;
      unique case (ph)
         PH_HEADER:    s = ST_SHORT_HEADER;
         PH_TLV_HEAD:  s = ST_TLV_HEAD_CUT;
         PH_TLV_VALUE: s = ST_TLV_VALUE_CUT;
         PH_PAYLOAD:   s = ST_PAYLOAD_CUT;
         default:      s = ST_SHORT_HEADER;
      endcase
      return s;
   endfunction

   function automatic logic [31:0] pos_to_word(logic [POSITION_BITS-1:0] p);
      logic [POSITION_BITS+31:0] wide;
      wide = {32'b0, p};
      return wide[31:0];
   endfunction

endpackage

/* rtl/core/tlvmv_req_if.sv */
interface tlvmv_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;
   logic       last_byte;

   modport source (output valid, output byte_value, output last_byte, input ready);
   modport sink (input valid, input byte_value, input last_byte, output ready);
endinterface

/* rtl/core/tlvmv_rsp_if.sv */
interface tlvmv_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [15:0] msg_type;
   logic [15:0] tlv_count;
   logic [31:0] payload_length;
   logic [31:0] payload_offset;
   logic        found;
   logic [31:0] found_offset;
   logic [15:0] found_length;

   modport source (output valid, output status, output msg_type, output tlv_count,
                   output payload_length, output payload_offset, output found,
                   output found_offset, output found_length, input ready);
   modport sink (input valid, input status, input msg_type, input tlv_count,
                 input payload_length, input payload_offset, input found,
                 input found_offset, input found_length, output ready);
endinterface

/* rtl/core/tlvmv_in_stage.sv */
module tlvmv_in_stage (
   input  logic                clock,
   input  logic                reset,
   tlvmv_req_if.sink           req_chan,
   output logic                item_valid,
   output tlvmv_pkg::item_type item,
   input  logic                item_take
);

   logic                valid_ff;
   tlvmv_pkg::item_type item_ff;

   assign req_chan.ready = !valid_ff || item_take;
   assign item_valid     = valid_ff;
   assign item           = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_chan.valid && req_chan.ready) begin
         valid_ff <= 1'b1;
      end else if (item_take) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         item_ff.byte_value <= req_chan.byte_value;
         item_ff.last_byte  <= req_chan.last_byte;
      end
   end

endmodule

/* rtl/core/tlvmv_parser.sv */
module tlvmv_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [15:0]           csr_write_data,
   input  logic                  item_valid,
   input  tlvmv_pkg::item_type   item,
   input  logic                  out_space,
   output logic                  item_take,
   output logic                  result_valid,
   output tlvmv_pkg::result_type result
);

   localparam int PB = tlvmv_pkg::POSITION_BITS;
   localparam int CB = tlvmv_pkg::POS_CMP_BITS;

   logic [15:0]          wanted_type_ff;
   logic [PB-1:0]        position_ff, position_in;
   tlvmv_pkg::phase_type phase_ff, phase_in;
   logic [63:0]          header_shift_ff, header_shift_in;
   logic [15:0]          tlvs_seen_ff, tlvs_seen_in;
   logic [31:0]          tlv_head_shift_ff, tlv_head_shift_in;
   logic [1:0]           head_bytes_ff, head_bytes_in;
   logic [15:0]          value_left_ff, value_left_in;
   logic [PB-1:0]        payload_start_ff, payload_start_in;
   logic                 match_seen_ff, match_seen_in;
   logic [PB-1:0]        match_offset_ff, match_offset_in;
   logic [15:0]          match_length_ff, match_length_in;
   logic [2:0]           error_code_ff, error_code_in;

   assign item_take    = item_valid && (!item.last_byte || out_space);
   assign result_valid = item_take && item.last_byte;

   always_comb begin
      logic [15:0] seen_inc;
      logic [15:0] head_len;
      logic        finish;
      position_in       = position_ff;
      phase_in          = phase_ff;
      header_shift_in   = header_shift_ff;
      tlvs_seen_in      = tlvs_seen_ff;
      tlv_head_shift_in = tlv_head_shift_ff;
      head_bytes_in     = head_bytes_ff;
      value_left_in     = value_left_ff;
      payload_start_in  = payload_start_ff;
      match_seen_in     = match_seen_ff;
      match_offset_in   = match_offset_ff;
      match_length_in   = match_length_ff;
      error_code_in     = error_code_ff;
      seen_inc          = tlvs_seen_ff + 16'd1;
      head_len          = {tlv_head_shift_ff[7:0], item.byte_value};
      finish            = 1'b0;
      if (error_code_ff == 3'(tlvmv_pkg::ST_VALID)) begin
         if (&position_ff) begin
            error_code_in = tlvmv_pkg::phase_status(phase_ff);
         end else begin
            position_in = position_ff + PB'(1);
            unique case (phase_ff)
               tlvmv_pkg::PH_HEADER: begin
                  header_shift_in = {header_shift_ff[55:0], item.byte_value};
                  if (position_in == PB'(tlvmv_pkg::HEADER_BYTES)) begin
                     payload_start_in = position_in;
                     phase_in = (header_shift_in[47:32] == 16'd0) ?
                                tlvmv_pkg::PH_PAYLOAD : tlvmv_pkg::PH_TLV_HEAD;
                  end
               end
               tlvmv_pkg::PH_TLV_HEAD: begin
                  tlv_head_shift_in = {tlv_head_shift_ff[23:0], item.byte_value};
                  head_bytes_in     = head_bytes_ff + 2'd1;
                  if (head_bytes_ff == 2'(tlvmv_pkg::TLV_HEAD_BYTES - 1)) begin
                     if (!match_seen_ff && tlv_head_shift_ff[23:8] == wanted_type_ff) begin
                        match_seen_in   = 1'b1;
                        match_offset_in = position_in;
                        match_length_in = head_len;
                     end
                     if (head_len == 16'd0) begin
                        finish = 1'b1;
                     end else begin
                        value_left_in = head_len;
                        phase_in      = tlvmv_pkg::PH_TLV_VALUE;
                     end
                  end
               end
               tlvmv_pkg::PH_TLV_VALUE: begin
                  value_left_in = value_left_ff - 16'd1;
                  finish        = (value_left_in == 16'd0);
               end
               tlvmv_pkg::PH_PAYLOAD: begin
               end
               default: begin
               end
            endcase
            if (finish) begin
               tlvs_seen_in = seen_inc;
               if (seen_inc == header_shift_ff[47:32]) begin
                  phase_in         = tlvmv_pkg::PH_PAYLOAD;
                  payload_start_in = position_in;
               end else begin
                  phase_in = tlvmv_pkg::PH_TLV_HEAD;
               end
            end
         end
      end
   end

   always_comb begin
      logic [CB-1:0] span;
      logic [2:0]    st;
      logic          ok;
      span = CB'(position_in) - CB'(payload_start_in);
      if (error_code_in != 3'(tlvmv_pkg::ST_VALID)) begin
         st = error_code_in;
      end else if (phase_in == tlvmv_pkg::PH_PAYLOAD) begin
         st = (span >= CB'(header_shift_in[31:0])) ? 3'(tlvmv_pkg::ST_VALID) :
              3'(tlvmv_pkg::ST_PAYLOAD_CUT);
      end else begin
         st = tlvmv_pkg::phase_status(phase_in);
      end
      ok = (st == 3'(tlvmv_pkg::ST_VALID));
      result.status = st;
      if (phase_in != tlvmv_pkg::PH_HEADER) begin
         result.msg_type       = header_shift_in[63:48];
         result.tlv_count      = header_shift_in[47:32];
         result.payload_length = header_shift_in[31:0];
      end else begin
         result.msg_type       = 16'd0;
         result.tlv_count      = 16'd0;
         result.payload_length = 32'd0;
      end
      result.payload_offset = ok ? tlvmv_pkg::pos_to_word(payload_start_in) : 32'd0;
      result.found          = ok && match_seen_in;
      result.found_offset   = (ok && match_seen_in) ?
                              tlvmv_pkg::pos_to_word(match_offset_in) : 32'd0;
      result.found_length   = (ok && match_seen_in) ? match_length_in : 16'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wanted_type_ff <= 16'd0;
      end else if (csr_write_enable) begin
         wanted_type_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || result_valid) begin
         position_ff       <= '0;
         phase_ff          <= tlvmv_pkg::PH_HEADER;
         header_shift_ff   <= 64'd0;
         tlvs_seen_ff      <= 16'd0;
         tlv_head_shift_ff <= 32'd0;
         head_bytes_ff     <= 2'd0;
         value_left_ff     <= 16'd0;
         payload_start_ff  <= '0;
         match_seen_ff     <= 1'b0;
         match_offset_ff   <= '0;
         match_length_ff   <= 16'd0;
         error_code_ff     <= 3'd0;
      end else if (item_take) begin
         position_ff       <= position_in;
         phase_ff          <= phase_in;
         header_shift_ff   <= header_shift_in;
         tlvs_seen_ff      <= tlvs_seen_in;
         tlv_head_shift_ff <= tlv_head_shift_in;
         head_bytes_ff     <= head_bytes_in;
         value_left_ff     <= value_left_in;
         payload_start_ff  <= payload_start_in;
         match_seen_ff     <= match_seen_in;
         match_offset_ff   <= match_offset_in;
         match_length_ff   <= match_length_in;
         error_code_ff     <= error_code_in;
      end
   end

endmodule

/* rtl/core/tlvmv_out_stage.sv */
module tlvmv_out_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  result_valid,
   input  tlvmv_pkg::result_type result,
   output logic                  out_space,
   tlvmv_rsp_if.source           rsp_chan
);

   logic                  valid_ff;
   tlvmv_pkg::result_type result_ff;

   assign out_space = !valid_ff || rsp_chan.ready;

   assign rsp_chan.valid          = valid_ff;
   assign rsp_chan.status         = result_ff.status;
   assign rsp_chan.msg_type       = result_ff.msg_type;
   assign rsp_chan.tlv_count      = result_ff.tlv_count;
   assign rsp_chan.payload_length = result_ff.payload_length;
   assign rsp_chan.payload_offset = result_ff.payload_offset;
   assign rsp_chan.found          = result_ff.found;
   assign rsp_chan.found_offset   = result_ff.found_offset;
   assign rsp_chan.found_length   = result_ff.found_length;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (result_valid) begin
         valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (result_valid) begin
         result_ff <= result;
      end
   end

endmodule

/* rtl/core/tlv_message_validator_core.sv */
// Channel    Dir  Transfer              Payload
// req_chan   in   valid && ready        byte_value[7:0], last_byte
// rsp_chan   out  valid && ready        status, msg_type, tlv_count, payload_length,
//                                       payload_offset, found, found_offset, found_length
// csr        in   csr_write_enable      csr_write_data[15:0] = wanted_type
//
// One byte per cycle sustained while the output has space; a byte is held in the input
// register; on the last byte its result is registered into the output register when taken.
// The per-byte counter and header updates are one pass of logic between the two registers.
// Synchronous active-high reset clears all control state and the wanted type.
// A stalled response holds only a last byte; other bytes keep flowing.
module tlv_message_validator_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data,
   tlvmv_req_if.sink   req_chan,
   tlvmv_rsp_if.source rsp_chan
);

   logic                  item_valid;
   tlvmv_pkg::item_type   item;
   logic                  item_take;
   logic                  out_space;
   logic                  result_valid;
   tlvmv_pkg::result_type result;

   tlvmv_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take)
   );

   tlvmv_parser u_parser (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .item_valid       (item_valid),
      .item             (item),
      .out_space        (out_space),
      .item_take        (item_take),
      .result_valid     (result_valid),
      .result           (result)
   );

   tlvmv_out_stage u_out_stage (
      .clock        (clock),
      .reset        (reset),
      .result_valid (result_valid),
      .result       (result),
      .out_space    (out_space),
      .rsp_chan     (rsp_chan)
   );

endmodule

/* test/testbench.sv */
module testbench;
   import tlvmv_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 300;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #2 clock = ~clock;

   logic        offer_valid = 1'b0;
   item_type    offer_item  = '0;
   logic        take_ready  = 1'b0;
   logic        csr_we      = 1'b0;
   logic [15:0] csr_wd      = '0;

   tlvmv_req_if req_bus();
   tlvmv_rsp_if rsp_bus();

   assign req_bus.valid      = offer_valid;
   assign req_bus.byte_value = offer_item.byte_value;
   assign req_bus.last_byte  = offer_item.last_byte;
   assign rsp_bus.ready      = take_ready;

   tlv_message_validator_core dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_we),
      .csr_write_data   (csr_wd),
      .req_chan         (req_bus),
      .rsp_chan         (rsp_bus)
   );

   item_type   byte_backlog[$];
   result_type expected_reports[$];
   logic [7:0] msg_bytes[$];

   int failures      = 0;
   int idle_cycles   = 0;
   int hold_left     = 0;
   bit hold_armed    = 1'b0;
   bit hold_done     = 1'b0;
   bit calm          = 1'b0;
   int items_made    = 0;

   logic [15:0]              wanted_copy   = '0;
   logic [POSITION_BITS-1:0] scan_pos      = '0;
   phase_type                scan_phase    = PH_HEADER;
   logic [63:0]              head_word     = '0;
   logic [15:0]              tlvs_done     = '0;
   logic [31:0]              tlv_word      = '0;
   int                       tlv_bytes     = 0;
   logic [15:0]              value_left    = '0;
   logic [POSITION_BITS-1:0] payload_at    = '0;
   bit                       hit_seen      = 1'b0;
   logic [POSITION_BITS-1:0] hit_at        = '0;
   logic [15:0]              hit_len       = '0;
   status_type               sticky_status = ST_VALID;

   function automatic void close_tlv();
      tlvs_done = tlvs_done + 16'd1;
      if (tlvs_done == head_word[47:32]) begin
         scan_phase = PH_PAYLOAD;
         payload_at = scan_pos;
      end else begin
         scan_phase = PH_TLV_HEAD;
      end
   endfunction

   function automatic void parse_byte(item_type it);
      result_type rep;
      status_type verdict;
      if (sticky_status == ST_VALID) begin
         if (scan_pos == '1) begin
            case (scan_phase)
               PH_HEADER:    sticky_status = ST_SHORT_HEADER;
               PH_TLV_HEAD:  sticky_status = ST_TLV_HEAD_CUT;
               PH_TLV_VALUE: sticky_status = ST_TLV_VALUE_CUT;
               default:      sticky_status = ST_PAYLOAD_CUT;
            endcase
         end else begin
            scan_pos = scan_pos + POSITION_BITS'(1);
            case (scan_phase)
               PH_HEADER: begin
                  head_word = {head_word[55:0], it.byte_value};
                  if (scan_pos == POSITION_BITS'(HEADER_BYTES)) begin
                     if (head_word[47:32] == 16'd0) begin
                        scan_phase = PH_PAYLOAD;
                        payload_at = scan_pos;
                     end else begin
                        scan_phase = PH_TLV_HEAD;
                     end
                  end
               end
               PH_TLV_HEAD: begin
                  tlv_word = {tlv_word[23:0], it.byte_value};
                  tlv_bytes++;
                  if (tlv_bytes == TLV_HEAD_BYTES) begin
                     tlv_bytes = 0;
                     if (!hit_seen && tlv_word[31:16] == wanted_copy) begin
                        hit_seen = 1'b1;
                        hit_at   = scan_pos;
                        hit_len  = tlv_word[15:0];
                     end
                     if (tlv_word[15:0] == 16'd0) begin
                        close_tlv();
                     end else begin
                        value_left = tlv_word[15:0];
                        scan_phase = PH_TLV_VALUE;
                     end
                  end
               end
               PH_TLV_VALUE: begin
                  value_left = value_left - 16'd1;
                  if (value_left == 16'd0) close_tlv();
               end
               default: ;
            endcase
         end
      end
      if (it.last_byte) begin
         if (sticky_status != ST_VALID) begin
            verdict = sticky_status;
         end else begin
            case (scan_phase)
               PH_HEADER:    verdict = ST_SHORT_HEADER;
               PH_TLV_HEAD:  verdict = ST_TLV_HEAD_CUT;
               PH_TLV_VALUE: verdict = ST_TLV_VALUE_CUT;
               default:
                  verdict = (scan_pos - payload_at >= head_word[31:0]) ? ST_VALID
                                                                       : ST_PAYLOAD_CUT;
            endcase
         end
         rep = '0;
         rep.status = verdict;
         if (scan_phase != PH_HEADER) begin
            rep.msg_type       = head_word[63:48];
            rep.tlv_count      = head_word[47:32];
            rep.payload_length = head_word[31:0];
         end
         if (verdict == ST_VALID) begin
            rep.payload_offset = 32'(payload_at);
            if (hit_seen) begin
               rep.found        = 1'b1;
               rep.found_offset = 32'(hit_at);
               rep.found_length = hit_len;
            end
         end
         expected_reports.push_back(rep);
         scan_pos      = '0;
         scan_phase    = PH_HEADER;
         head_word     = '0;
         tlvs_done     = '0;
         tlv_word      = '0;
         tlv_bytes     = 0;
         value_left    = '0;
         payload_at    = '0;
         hit_seen      = 1'b0;
         hit_at        = '0;
         hit_len       = '0;
         sticky_status = ST_VALID;
      end
   endfunction

   task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         failures++;
         if (failures <= 10)
            $display("mismatch on %s: expected %0h, got %0h", name, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         offer_valid <= 1'b0;
      end else begin
         if (offer_valid && req_bus.ready) parse_byte(byte_backlog.pop_front());
         if (!offer_valid || req_bus.ready) begin
            if (byte_backlog.size() > 0 && (calm || $urandom_range(99) >= 30)) begin
               offer_valid <= 1'b1;
               offer_item  <= byte_backlog[0];
            end else begin
               offer_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         take_ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && take_ready) begin
            if (expected_reports.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("unexpected transfer: status %0d", rsp_bus.status);
            end else begin
               want = expected_reports.pop_front();
               compare_field("status", 32'(want.status), 32'(rsp_bus.status));
               compare_field("msg_type", 32'(want.msg_type), 32'(rsp_bus.msg_type));
               compare_field("tlv_count", 32'(want.tlv_count), 32'(rsp_bus.tlv_count));
               compare_field("payload_length", want.payload_length, rsp_bus.payload_length);
               compare_field("payload_offset", want.payload_offset, rsp_bus.payload_offset);
               compare_field("found", 32'(want.found), 32'(rsp_bus.found));
               compare_field("found_offset", want.found_offset, rsp_bus.found_offset);
               compare_field("found_length", 32'(want.found_length),
                             32'(rsp_bus.found_length));
            end
         end
         if (hold_left > 0) begin
            hold_left  <= hold_left - 1;
            take_ready <= 1'b0;
         end else if (hold_armed && !hold_done) begin
            hold_left  <= HOLD_CYCLES;
            hold_done  <= 1'b1;
            take_ready <= 1'b0;
         end else begin
            take_ready <= calm || $urandom_range(99) >= 30;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (offer_valid && req_bus.ready) || (rsp_bus.valid && take_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic put_bytes(logic [63:0] v, int n);
      for (int i = n - 1; i >= 0; i--) msg_bytes.push_back(v[8*i +: 8]);
   endtask

   task automatic put_tlv(logic [15:0] kind, logic [15:0] len);
      put_bytes(64'({kind, len}), 4);
      repeat (len) put_bytes(64'($urandom()), 1);
   endtask

   task automatic emit_message(int keep);
      item_type it;
      if (keep < 1 || keep > msg_bytes.size()) keep = msg_bytes.size();
      for (int i = 0; i < keep; i++) begin
         it.byte_value = msg_bytes[i];
         it.last_byte  = (i == keep - 1);
         byte_backlog.push_back(it);
      end
      msg_bytes.delete();
      items_made += keep;
   endtask

   task automatic random_message();
      int          roll;
      int          ntlv;
      int          plen;
      logic [15:0] kind;
      logic [15:0] count_field;
      logic [31:0] length_field;
      roll = $urandom_range(99);
      if (roll < 12) begin
         repeat ($urandom_range(1, 12)) put_bytes(64'($urandom()), 1);
         emit_message(0);
      end else begin
         ntlv = $urandom_range(0, 3);
         plen = $urandom_range(0, 4);
         count_field  = (roll < 20) ? 16'($urandom()) : 16'(ntlv);
         length_field = (roll < 20) ? 32'($urandom()) : 32'(plen);
         put_bytes({16'($urandom()), count_field, length_field}, 8);
         for (int i = 0; i < ntlv; i++) begin
            kind = ($urandom_range(2) == 0) ? wanted_copy : 16'($urandom());
            put_tlv(kind, ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom_range(1, 4)));
         end
         repeat (plen + $urandom_range(0, 2)) put_bytes(64'($urandom()), 1);
         emit_message((roll < 35) ? $urandom_range(1, msg_bytes.size()) : 0);
      end
   endtask

   task automatic wait_drained();
      while (byte_backlog.size() != 0 || offer_valid || expected_reports.size() != 0)
         @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      logic [15:0] settings[4];
      settings = '{16'hFFFF, 16'($urandom()), 16'h0000, 16'($urandom())};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      put_bytes(64'(8'hA5), 1);
      emit_message(0);
      put_bytes({16'hFFFF, 16'h0000, 32'h0000_0000}, 8);
      emit_message(0);
      put_bytes({16'h0001, 16'h0001, 32'h0000_0001}, 8);
      put_tlv(16'h0000, 16'h0000);
      put_bytes(64'(8'h5A), 1);
      emit_message(0);

      foreach (settings[p]) begin
         wait_drained();
         csr_we      <= 1'b1;
         csr_wd      <= settings[p];
         wanted_copy  = settings[p];
         @(posedge clock);
         csr_we <= 1'b0;
         @(negedge clock);
         calm       = (p == 1);
         hold_armed = (p == 2);
         items_made = 0;
         while (items_made < 100) random_message();
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (failures == 0 && expected_reports.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/tlvmv_pkg.sv
rtl/core/tlvmv_req_if.sv
rtl/core/tlvmv_rsp_if.sv
rtl/core/tlvmv_in_stage.sv
rtl/core/tlvmv_parser.sv
rtl/core/tlvmv_out_stage.sv
rtl/core/tlv_message_validator_core.sv
test/testbench.sv
